// ===== rtl/mstt_pkg.sv =====
// Shared constants, types and control structs for the multi-slot tick timer.
package mstt_pkg;

	// Slot table size and derived index width.
	localparam int SLOT_COUNT = 4;
	localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	// Field widths.
	localparam int SLOT_W   = 4;
	localparam int TICKS_W  = 15;
	localparam int COUNT_W  = 32;
	localparam int FIRED_W  = 4;
	localparam int RATE_W   = 4;
	localparam int MS_W     = 14;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 56;

	// Rate selection limits and the base tick length in milliseconds.
	localparam logic [RATE_W-1:0] RATE_MAX = RATE_W'(9);
	localparam logic [MS_W-1:0]   BASE_MS  = MS_W'(16);

	// Status codes of a result.
	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_BAD_IDX = 1'b1;

	// Item kinds carried in tuser.
	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_PROG = 1'b1;

	// Kind of a slot.
	typedef enum logic [1:0] {
		KIND_EMPTY    = 2'd0,
		KIND_PERIODIC = 2'd1,
		KIND_ONESHOT  = 2'd2
	} slot_kind_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;       // capture the input transaction
		logic prog;       // program the captured slot
		logic inc;        // advance the tick count
		logic div_start;  // start the remainder unit on the current slot
		logic eval;       // decide the current slot and step to the next
		logic put;        // load the result into the output register
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_div;   // current slot is periodic with a nonzero period
		logic last_slot;  // current slot is the last one
		logic div_busy;   // remainder unit is working
		logic div_done;   // remainder unit finished in the previous cycle
		logic out_free;   // output register can take a result
	} dp_status_t;

endpackage

// ===== rtl/mstt_div.sv =====
// Bit-serial remainder unit: 32-bit count modulo a 15-bit period.
module mstt_div
	import mstt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [COUNT_W-1:0] dividend,
	input  logic [TICKS_W-1:0] divisor,
	output logic               busy,
	output logic               done,
	output logic [TICKS_W-1:0] rem
);

	localparam int STEP_W = $clog2(COUNT_W);

	logic [COUNT_W-1:0] dvd_q;
	logic [TICKS_W-1:0] dsr_q;
	logic [TICKS_W-1:0] rem_q;
	logic [STEP_W-1:0]  step_q;
	logic               busy_q;
	logic               done_q;
	logic [TICKS_W:0]   trial;
	logic [TICKS_W:0]   diff;

	// One restoring step: shift in the next dividend bit, subtract if it fits.
	always_comb begin
		trial = {rem_q, dvd_q[COUNT_W-1]};
		diff  = trial - {1'b0, dsr_q};
	end

	// Step sequencing; the remainder stays valid until the next start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(COUNT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and partial remainder registers.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[COUNT_W-2:0], 1'b0};
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= diff[TICKS_W-1:0];
			end else begin
				rem_q <= trial[TICKS_W-1:0];
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/mstt_dp.sv =====
// Datapath: tick count, slot table, rate register, remainder unit and output register.
module mstt_dp
	import mstt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  ctrl_cmd_t           cmd,
	output dp_status_t          sts,
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic                cfg_valid,
	input  logic [RATE_W-1:0]   cfg_data,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata
);

	logic [COUNT_W-1:0] count_q;
	logic [RATE_W-1:0]  rate_q;
	slot_kind_t         kind_q [SLOT_COUNT];
	logic [COUNT_W-1:0] value_q [SLOT_COUNT];

	logic [SLOT_W-1:0]  slot_q;
	logic               periodic_q;
	logic [TICKS_W-1:0] ticks_q;
	logic [IDX_W-1:0]   idx_q;
	logic [FIRED_W-1:0] fired_q;
	logic               status_q;

	logic               out_valid_q;
	logic [FIRED_W-1:0] out_fired_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               out_status_q;
	logic [MS_W-1:0]    out_ms_q;

	slot_kind_t         cur_kind;
	logic [COUNT_W-1:0] cur_value;
	logic               slot_ok;
	logic               hit;
	logic               div_busy;
	logic               div_done;
	logic [TICKS_W-1:0] div_rem;

	// Current slot of the scan and whether it fires.
	always_comb begin
		cur_kind  = kind_q[idx_q];
		cur_value = value_q[idx_q];
		slot_ok   = ({1'b0, slot_q} < (SLOT_W + 1)'(SLOT_COUNT));
		unique case (cur_kind)
			KIND_PERIODIC: hit = (cur_value != '0) && (div_rem == '0);
			KIND_ONESHOT:  hit = (count_q >= cur_value);
			default:       hit = 1'b0;
		endcase
	end

	mstt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (count_q),
		.divisor  (cur_value[TICKS_W-1:0]),
		.busy     (div_busy),
		.done     (div_done),
		.rem      (div_rem)
	);

	// Tick count and rate register; an in-range rate write restarts the count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rate_q  <= '0;
		end else if (cfg_valid && (cfg_data <= RATE_MAX)) begin
			count_q <= '0;
			rate_q  <= cfg_data;
		end else if (cmd.inc) begin
			count_q <= count_q + COUNT_W'(1);
		end
	end

	// Slot kinds; a one-shot that fires empties its slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				kind_q[i] <= KIND_EMPTY;
			end
		end else if (cmd.prog && slot_ok) begin
			kind_q[slot_q[IDX_W-1:0]] <= periodic_q ? KIND_PERIODIC : KIND_ONESHOT;
		end else if (cmd.eval && hit && (cur_kind == KIND_ONESHOT)) begin
			kind_q[idx_q] <= KIND_EMPTY;
		end
	end

	// Slot values: the period, or the deadline of a one-shot.
	always_ff @(posedge clk) begin
		if (cmd.prog && slot_ok) begin
			if (periodic_q) begin
				value_q[slot_q[IDX_W-1:0]] <= COUNT_W'(ticks_q);
			end else begin
				value_q[slot_q[IDX_W-1:0]] <= count_q + COUNT_W'(ticks_q);
			end
		end
	end

	// Captured transaction fields.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			slot_q     <= s_tdata[SLOT_W-1:0];
			periodic_q <= s_tdata[SLOT_W];
			ticks_q    <= s_tdata[SLOT_W+TICKS_W:SLOT_W+1];
		end
	end

	// Scan index, fire mask and status of the item at work.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			fired_q  <= '0;
			status_q <= STATUS_OK;
		end else if (cmd.take) begin
			idx_q    <= '0;
			fired_q  <= '0;
			status_q <= STATUS_OK;
		end else begin
			if (cmd.prog && !slot_ok) begin
				status_q <= STATUS_BAD_IDX;
			end
			if (cmd.eval) begin
				fired_q <= fired_q | (FIRED_W'(hit) << idx_q);
				idx_q   <= idx_q + IDX_W'(1);
			end
		end
	end

	// Output register: holds a finished result until its transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.put) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.put) begin
			out_fired_q  <= fired_q;
			out_count_q  <= count_q;
			out_status_q <= status_q;
			out_ms_q     <= BASE_MS << rate_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(M_DATA_W - FIRED_W - COUNT_W - 1 - MS_W)'(0),
		out_ms_q, out_status_q, out_count_q, out_fired_q};

	// Status toward the controller.
	always_comb begin
		sts.need_div  = (cur_kind == KIND_PERIODIC) && (cur_value != '0);
		sts.last_slot = (idx_q == IDX_W'(SLOT_COUNT - 1));
		sts.div_busy  = div_busy;
		sts.div_done  = div_done;
		sts.out_free  = !out_valid_q || m_tready;
	end

endmodule

// ===== rtl/mstt_ctrl.sv =====
// Controller state machine sequencing ticks, slot scans and programming requests.
module mstt_ctrl
	import mstt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tuser,
	output logic       s_tready,
	input  dp_status_t sts,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INC,
		ST_SCAN,
		ST_DIV,
		ST_PROG,
		ST_PUT
	} state_t;

	state_t state_q;

	// Commands decoded from the state and datapath status.
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.take = s_tvalid;
			end
			ST_INC:  cmd.inc = 1'b1;
			ST_SCAN: begin
				cmd.div_start = sts.need_div;
				cmd.eval      = !sts.need_div;
			end
			ST_DIV:  cmd.eval = sts.div_done;
			ST_PROG: cmd.prog = 1'b1;
			ST_PUT:  cmd.put = sts.out_free;
			default: cmd = '0;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= (s_tuser == MODE_PROG) ? ST_PROG : ST_INC;
					end
				end
				ST_INC:  state_q <= ST_SCAN;
				ST_SCAN: begin
					if (sts.need_div) begin
						state_q <= ST_DIV;
					end else if (sts.last_slot) begin
						state_q <= ST_PUT;
					end
				end
				ST_DIV: begin
					if (sts.div_done) begin
						state_q <= sts.last_slot ? ST_PUT : ST_SCAN;
					end
				end
				ST_PROG: state_q <= ST_PUT;
				ST_PUT: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/multi_slot_tick_timer.sv =====
// Top level of the multi-slot tick timer: controller, datapath and checks.
//
// Each input transaction is either a tick or a request to program one timer
// slot, and each gives exactly one result transaction. A programming request
// passes from acceptance through the program state to the result register.
// A tick advances the count and then scans the slots in order: each periodic
// slot with a nonzero period needs a 32-bit remainder computed by a shared
// bit-serial unit at one quotient bit per cycle; other slots are decided
// without that unit. One item is at work at a time; a new input is taken
// while a finished result still waits in the output register. Rate writes on
// the cfg channel are always ready and are meant to arrive while the block
// idles.
module multi_slot_tick_timer
	import mstt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // slot[3:0], periodic[4], ticks[19:5], zero pad
	input  logic                s_tuser,   // mode
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // fired[3:0], tick_count[35:4], status[36],
	                                       // tick_ms[50:37], zero pad
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [RATE_W-1:0]   cfg_data   // rate_select
);

	ctrl_cmd_t  cmd;
	dp_status_t sts;

	assign cfg_ready = 1'b1;

	mstt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mstt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

`ifndef ASSERT_OFF
	// A result is only loaded when the output register can take it.
	a_put_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put |-> sts.out_free)
		else $error("result loaded into a full output register");

	// The remainder unit is never restarted while it works.
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("remainder unit restarted while busy");

	// At most one datapath command is issued in a cycle.
	a_cmd_one: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.take, cmd.prog, cmd.inc, cmd.div_start, cmd.eval, cmd.put}))
		else $error("more than one datapath command");

	// A started remainder unit is busy in the following cycle.
	a_div_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> sts.div_busy)
		else $error("remainder unit failed to start");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the multi-slot tick timer, with a timer predictor and stream checks.
module tb
	import mstt_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 150;
	localparam int PHASE_ITEMS    = 330;

	// One input item and one result item as the timer sees them.
	typedef struct {
		logic               mode;
		logic [SLOT_W-1:0]  slot;
		logic               periodic;
		logic [TICKS_W-1:0] ticks;
	} timer_item_t;

	typedef struct {
		logic [FIRED_W-1:0] fired;
		logic [COUNT_W-1:0] count;
		logic               status;
		logic [MS_W-1:0]    ms;
	} timer_result_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata   = '0;
	logic                s_tuser   = MODE_TICK;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [RATE_W-1:0]   cfg_data  = '0;

	// Predicted timer state.
	logic [COUNT_W-1:0] count_model = '0;
	logic [RATE_W-1:0]  rate_model  = '0;
	slot_kind_t         kind_model  [SLOT_COUNT];
	logic [COUNT_W-1:0] value_model [SLOT_COUNT];

	timer_item_t   items_to_send[$];
	timer_result_t timer_results_due[$];
	timer_item_t   on_bus;
	int            send_idle_pct  = 0;
	int            recv_stall_pct = 0;
	int            mismatch_count = 0;
	int            idle_cycles    = 0;

	multi_slot_tick_timer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Advance the predicted state by one item and return the result it produces.
	function automatic timer_result_t predict_timer(timer_item_t it);
		timer_result_t r;
		r.fired  = '0;
		r.status = STATUS_OK;
		if (it.mode == MODE_TICK) begin
			count_model = count_model + COUNT_W'(1);
			for (int i = 0; i < SLOT_COUNT; i++) begin
				logic hit;
				hit = 1'b0;
				if (kind_model[i] == KIND_PERIODIC) begin
					hit = (value_model[i] != '0) && (count_model % value_model[i] == '0);
				end else if (kind_model[i] == KIND_ONESHOT && count_model >= value_model[i]) begin
					hit = 1'b1;
					kind_model[i]  = KIND_EMPTY;
					value_model[i] = '0;
				end
				if (hit && i < FIRED_W)
					r.fired[i] = 1'b1;
			end
		end else if (it.slot >= SLOT_COUNT) begin
			r.status = STATUS_BAD_IDX;
		end else if (it.periodic) begin
			kind_model[it.slot[IDX_W-1:0]]  = KIND_PERIODIC;
			value_model[it.slot[IDX_W-1:0]] = COUNT_W'(it.ticks);
		end else begin
			kind_model[it.slot[IDX_W-1:0]]  = KIND_ONESHOT;
			value_model[it.slot[IDX_W-1:0]] = count_model + COUNT_W'(it.ticks);
		end
		r.count = count_model;
		r.ms    = BASE_MS << rate_model;
		return r;
	endfunction

	function automatic timer_item_t random_item();
		timer_item_t it;
		int pick;
		it.slot     = SLOT_W'($urandom_range(15));
		it.periodic = 1'($urandom_range(1));
		it.ticks    = TICKS_W'($urandom_range(32767));
		pick = $urandom_range(99);
		// Ticks carry random noise in the fields the block ignores.
		if (pick < 55) begin
			it.mode = MODE_TICK;
		end else begin
			it.mode = MODE_PROG;
			if ($urandom_range(99) < 88)
				it.slot = SLOT_W'($urandom_range(SLOT_COUNT - 1));
			// Mostly short periods and delays so that slots actually fire.
			pick = $urandom_range(99);
			if (pick < 60)
				it.ticks = TICKS_W'($urandom_range(6));
			else if (pick < 85)
				it.ticks = TICKS_W'($urandom_range(40));
		end
		return it;
	endfunction

	task automatic queue_tick(logic [SLOT_W-1:0] slot, logic periodic, logic [TICKS_W-1:0] ticks);
		items_to_send.push_back('{MODE_TICK, slot, periodic, ticks});
	endtask

	task automatic queue_prog(logic [SLOT_W-1:0] slot, logic periodic, logic [TICKS_W-1:0] ticks);
		items_to_send.push_back('{MODE_PROG, slot, periodic, ticks});
	endtask

	// Hold the sender until nothing is queued, on the bus or still owed by the block.
	task automatic wait_idle();
		while (items_to_send.size() != 0 || s_tvalid || timer_results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_rate(logic [RATE_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		// Out-of-range values leave everything as it was.
		if (value <= RATE_MAX) begin
			rate_model  = value;
			count_model = '0;
		end
	endtask

	task automatic run_phase(int send_pct, int recv_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		repeat (PHASE_ITEMS)
			items_to_send.push_back(random_item());
		wait_idle();
	endtask

	task automatic check_field(string field, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatch_count++;
		end
	endtask

	// Input driver: predicts each accepted transaction and presents the next pending item.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				timer_results_due.push_back(predict_timer(on_bus));
			if (!s_tvalid || s_tready) begin
				if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					on_bus = items_to_send.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {4'b0, on_bus.ticks, on_bus.periodic, on_bus.slot};
					s_tuser  <= on_bus.mode;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and watchdog.
	always @(posedge clk) begin
		timer_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (timer_results_due.size() == 0) begin
					$error("result transaction with nothing expected: tdata %h", m_tdata);
					mismatch_count++;
				end else begin
					want = timer_results_due.pop_front();
					check_field("fired", 64'(want.fired), 64'(m_tdata[3:0]));
					check_field("tick_count", 64'(want.count), 64'(m_tdata[35:4]));
					check_field("status", 64'(want.status), 64'(m_tdata[36]));
					check_field("tick_ms", 64'(want.ms), 64'(m_tdata[50:37]));
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$error("no transaction for %0d cycles", WATCHDOG_LIMIT);
					$display("Mismatches found");
					$finish;
				end
			end
		end
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			kind_model[i]  = KIND_EMPTY;
			value_model[i] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: period zero, zero delay, bad indexes, reprogramming, all slots periodic.
		queue_tick(4'd15, 1'b1, 15'h7FFF);
		queue_prog(4'd0, 1'b1, 15'd0);
		queue_prog(4'd1, 1'b1, 15'd2);
		queue_prog(4'd2, 1'b0, 15'd0);
		queue_prog(4'd3, 1'b0, 15'd3);
		queue_prog(4'd4, 1'b1, 15'h7FFF);
		queue_prog(4'd15, 1'b0, 15'h7FFF);
		queue_tick(4'd0, 1'b0, 15'd0);
		queue_tick(4'd0, 1'b0, 15'd0);
		queue_tick(4'd0, 1'b0, 15'd0);
		queue_prog(4'd3, 1'b1, 15'h7FFF);
		queue_prog(4'd2, 1'b0, 15'h7FFF);
		queue_prog(4'd2, 1'b1, 15'd1);
		queue_tick(4'd0, 1'b0, 15'd0);
		queue_prog(4'd0, 1'b1, 15'd1);
		queue_prog(4'd1, 1'b1, 15'd1);
		queue_prog(4'd3, 1'b1, 15'd1);
		queue_tick(4'd0, 1'b0, 15'd0);
		queue_tick(4'd0, 1'b0, 15'd0);
		wait_idle();

		// Rate writes out of range and at both ends of the range.
		write_rate(4'd15);
		write_rate(4'd9);
		run_phase(0, 0);
		write_rate(4'd10);
		write_rate(4'd0);
		run_phase(58, 0);
		write_rate(RATE_W'($urandom_range(15)));
		run_phase(0, 58);
		write_rate(RATE_W'($urandom_range(15)));
		run_phase(11, 11);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && timer_results_due.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
